// File: rtl/edfs_pkg.sv
`default_nettype none

package edfs_pkg;

   localparam int MAX_SERVERS_DEFAULT = 128;

   // register reset values
   localparam logic [7:0]  COUNT_RESET = 8'd1;
   localparam logic [16:0] OPEN_RESET  = 17'd28800;
   localparam logic [16:0] CLOSE_RESET = 17'd61200;
   localparam logic [9:0]  CAP_RESET   = 10'd60;

   localparam logic [15:0] SECS_PER_MIN = 16'd60;
   localparam logic [47:0] SUM_MAX      = 48'hFFFF_FFFF_FFFF;
   localparam logic [31:0] FREE_MAX     = 32'hFFFF_FFFF;

   localparam int CSR_DATA_W = 17;

   typedef enum logic [1:0] {
      CSR_SERVER_COUNT = 2'd0,
      CSR_OPEN_TIME    = 2'd1,
      CSR_CLOSE_TIME   = 2'd2,
      CSR_MAX_SERVICE  = 2'd3
   } csr_index_type;

   typedef enum logic {
      OP_JOB   = 1'b0,
      OP_CLEAR = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_SCAN,
      ST_DRAIN,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic        operation;
      logic [16:0] arrival_time;
      logic [9:0]  service_minutes;
   } req_word_type;

   typedef struct packed {
      logic        dropped;
      logic [6:0]  server_index;
      logic [31:0] wait_seconds;
      logic [47:0] total_wait;
      logic [31:0] served_count;
   } rsp_word_type;

   // read data tag going into the minimum scan
   typedef struct packed {
      logic vld;
      logic first;
   } scan_ctrl_type;

endpackage

`default_nettype wire

// File: rtl/edfs_free_mem.sv
`default_nettype none

module edfs_free_mem #(
   parameter int DEPTH = edfs_pkg::MAX_SERVERS_DEFAULT,
   parameter int AW    = 7
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [31:0]   wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output      logic [31:0]   rd_data
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/edfs_min_scan.sv
`default_nettype none

module edfs_min_scan #(
   parameter int AW = 7
) (
   input  wire logic                    clock,
   input  wire edfs_pkg::scan_ctrl_type ctrl,
   input  wire logic [AW-1:0]           idx,
   input  wire logic [31:0]             data,
   output      logic [AW-1:0]           best_idx,
   output      logic [31:0]             best_val
);

   logic [AW-1:0] best_idx_ff;
   logic [31:0]   best_val_ff;

   // strict less-than keeps the lowest index on ties
   always_ff @(posedge clock) begin
      if (ctrl.vld && (ctrl.first || (data < best_val_ff))) begin
         best_idx_ff <= idx;
         best_val_ff <= data;
      end
   end

   assign best_idx = best_idx_ff;
   assign best_val = best_val_ff;

endmodule

`default_nettype wire

// File: rtl/earliest_free_server_dispatch.sv
`default_nettype none

// channel   ports                                   direction  handshake
// ------------------------------------------------------------------------------------
// request   start, busy, req_word                   in         word taken when start & !busy
// response  rsp_strobe, rsp_word                    out        word valid for one cycle
// csr       csr_write_en, csr_index, csr_wdata      in         written when csr_write_en
//
// a job word that is served keeps the block busy from accept until the next possible
// accept, passing the scan, drain and update states: one read per server in use from the free-at
// memory in scan, the last compare in drain, the write-back in update
// a job word dropped for arriving after closing leaves the block idle; a clear word
// keeps it busy while a pass rewrites every free-at entry
// after reset a clearing pass over every free-at entry runs before the first word
// is taken; csr writes are taken at any time
// a served job's response is valid in the cycle busy falls, a clear or dropped
// job's response in the cycle after its accept; the receiver cannot stall it

module earliest_free_server_dispatch #(
   parameter int MAX_SERVERS = edfs_pkg::MAX_SERVERS_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // request
   input  wire logic                                   start,
   output      logic                                   busy,
   input  wire edfs_pkg::req_word_type                 req_word,
   // response
   output      logic                                   rsp_strobe,
   output      edfs_pkg::rsp_word_type                 rsp_word,
   // csr
   input  wire logic                                   csr_write_en,
   input  wire edfs_pkg::csr_index_type                csr_index,
   input  wire logic [edfs_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int AW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_SERVERS - 1);

   // configuration registers
   logic [7:0]  server_count_ff;
   logic [16:0] open_time_ff;
   logic [16:0] close_time_ff;
   logic [9:0]  max_mins_ff;

   // control
   edfs_pkg::state_type state_ff, state_in;
   logic [AW-1:0] sweep_addr_ff;
   logic [AW-1:0] scan_addr_ff;
   logic [16:0]   fill_value_ff;
   logic          rd_vld_ff;
   logic          rd_first_ff;
   logic [AW-1:0] rd_idx_ff;

   // job in flight
   logic [16:0]   arrival_ff;
   logic [15:0]   service_ff;
   logic [AW-1:0] last_ff;

   // totals
   logic [47:0] wait_sum_ff;
   logic [31:0] job_count_ff;

   // response register
   logic                   rsp_strobe_ff;
   edfs_pkg::rsp_word_type rsp_word_ff;

   // decoded controls
   logic          accept;
   logic          take_clear;
   logic          take_drop;
   logic          take_job;
   logic          do_update;
   logic          sweeping;
   logic          scanning;
   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic [31:0]   mem_wr_data;
   logic [31:0]   mem_rd_data;

   // scan results
   edfs_pkg::scan_ctrl_type scan_ctrl;
   logic [AW-1:0] best_idx;
   logic [31:0]   best_val;

   // job setup values
   logic [31:0]   count_ext;
   logic [AW-1:0] last_calc;
   logic [9:0]    mins_cap;
   logic          late;

   // update arithmetic
   logic          server_busy;
   logic [31:0]   wait_calc;
   logic [31:0]   base_time;
   logic [32:0]   free_sum;
   logic [31:0]   new_free;
   logic [48:0]   wait_sum_add;
   logic [47:0]   new_wait_sum;
   logic [31:0]   new_job_count;
   logic [AW+6:0] idx_wide;

   assign busy   = (state_ff != edfs_pkg::ST_IDLE);
   assign accept = start && !busy;
   assign late   = (req_word.arrival_time > close_time_ff);

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         server_count_ff <= edfs_pkg::COUNT_RESET;
         open_time_ff    <= edfs_pkg::OPEN_RESET;
         close_time_ff   <= edfs_pkg::CLOSE_RESET;
         max_mins_ff     <= edfs_pkg::CAP_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            edfs_pkg::CSR_SERVER_COUNT: server_count_ff <= csr_wdata[7:0];
            edfs_pkg::CSR_OPEN_TIME:    open_time_ff    <= csr_wdata[16:0];
            edfs_pkg::CSR_CLOSE_TIME:   close_time_ff   <= csr_wdata[16:0];
            edfs_pkg::CSR_MAX_SERVICE:  max_mins_ff     <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         edfs_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_word.operation == edfs_pkg::OP_CLEAR) begin
                  state_in = edfs_pkg::ST_SWEEP;
               end else if (!late) begin
                  state_in = edfs_pkg::ST_SCAN;
               end
            end
         end
         edfs_pkg::ST_SWEEP: begin
            if (sweep_addr_ff == LAST_ADDR) begin
               state_in = edfs_pkg::ST_IDLE;
            end
         end
         edfs_pkg::ST_SCAN: begin
            if (scan_addr_ff == last_ff) begin
               state_in = edfs_pkg::ST_DRAIN;
            end
         end
         edfs_pkg::ST_DRAIN:  state_in = edfs_pkg::ST_UPDATE;
         edfs_pkg::ST_UPDATE: state_in = edfs_pkg::ST_IDLE;
         default:             state_in = edfs_pkg::ST_IDLE;
      endcase
   end

   // decoded outputs of the state machine
   always_comb begin
      take_clear = 1'b0;
      take_drop  = 1'b0;
      take_job   = 1'b0;
      do_update  = 1'b0;
      sweeping   = 1'b0;
      scanning   = 1'b0;
      case (state_ff)
         edfs_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_word.operation == edfs_pkg::OP_CLEAR) begin
                  take_clear = 1'b1;
               end else if (late) begin
                  take_drop = 1'b1;
               end else begin
                  take_job = 1'b1;
               end
            end
         end
         edfs_pkg::ST_SWEEP:  sweeping  = 1'b1;
         edfs_pkg::ST_SCAN:   scanning  = 1'b1;
         edfs_pkg::ST_DRAIN:  ;
         edfs_pkg::ST_UPDATE: do_update = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= edfs_pkg::ST_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

   // clearing pass address and fill value
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_addr_ff <= '0;
         fill_value_ff <= edfs_pkg::OPEN_RESET;
      end else if (take_clear) begin
         sweep_addr_ff <= '0;
         fill_value_ff <= open_time_ff;
      end else if (sweeping) begin
         sweep_addr_ff <= (sweep_addr_ff == LAST_ADDR) ? '0 : sweep_addr_ff + 1'b1;
      end
   end

   // scan read address and the tag of the word coming back from memory
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_addr_ff <= '0;
         rd_vld_ff    <= 1'b0;
      end else begin
         rd_vld_ff <= scanning;
         if (scanning) begin
            scan_addr_ff <= (scan_addr_ff == last_ff) ? '0 : scan_addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= scan_addr_ff;
      rd_first_ff <= (scan_addr_ff == '0);
   end

   // effective server count, service cap
   always_comb begin
      count_ext = 32'(server_count_ff);
      if (count_ext == 32'd0) begin
         last_calc = '0;
      end else if (count_ext > 32'(MAX_SERVERS)) begin
         last_calc = LAST_ADDR;
      end else begin
         last_calc = AW'(count_ext - 32'd1);
      end
      mins_cap = (req_word.service_minutes > max_mins_ff) ? max_mins_ff
                                                          : req_word.service_minutes;
   end

   always_ff @(posedge clock) begin
      if (take_job) begin
         arrival_ff <= req_word.arrival_time;
         service_ff <= 16'(mins_cap) * edfs_pkg::SECS_PER_MIN;
         last_ff    <= last_calc;
      end
   end

   edfs_free_mem #(
      .DEPTH (MAX_SERVERS),
      .AW    (AW)
   ) u_free_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (scanning),
      .rd_addr (scan_addr_ff),
      .rd_data (mem_rd_data)
   );

   assign scan_ctrl.vld   = rd_vld_ff;
   assign scan_ctrl.first = rd_first_ff;

   edfs_min_scan #(
      .AW (AW)
   ) u_min_scan (
      .clock    (clock),
      .ctrl     (scan_ctrl),
      .idx      (rd_idx_ff),
      .data     (mem_rd_data),
      .best_idx (best_idx),
      .best_val (best_val)
   );

   // write-back of the chosen server
   always_comb begin
      server_busy   = (best_val > 32'(arrival_ff));
      wait_calc     = server_busy ? (best_val - 32'(arrival_ff)) : 32'd0;
      base_time     = server_busy ? best_val : 32'(arrival_ff);
      free_sum      = 33'(base_time) + 33'(service_ff);
      new_free      = free_sum[32] ? edfs_pkg::FREE_MAX : free_sum[31:0];
      wait_sum_add  = 49'(wait_sum_ff) + 49'(wait_calc);
      new_wait_sum  = wait_sum_add[48] ? edfs_pkg::SUM_MAX : wait_sum_add[47:0];
      new_job_count = (&job_count_ff) ? job_count_ff : job_count_ff + 32'd1;
      idx_wide      = (AW + 7)'(best_idx);
   end

   assign mem_wr_en   = sweeping || do_update;
   assign mem_wr_addr = sweeping ? sweep_addr_ff : best_idx;
   assign mem_wr_data = sweeping ? 32'(fill_value_ff) : new_free;

   // totals
   always_ff @(posedge clock) begin
      if (reset || take_clear) begin
         wait_sum_ff  <= '0;
         job_count_ff <= '0;
      end else if (do_update) begin
         wait_sum_ff  <= new_wait_sum;
         job_count_ff <= new_job_count;
      end
   end

   // response word
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= take_clear || take_drop || do_update;
      end
   end

   always_ff @(posedge clock) begin
      if (take_clear) begin
         rsp_word_ff.dropped      <= 1'b1;
         rsp_word_ff.server_index <= '0;
         rsp_word_ff.wait_seconds <= '0;
         rsp_word_ff.total_wait   <= '0;
         rsp_word_ff.served_count <= '0;
      end else if (take_drop) begin
         rsp_word_ff.dropped      <= 1'b1;
         rsp_word_ff.server_index <= '0;
         rsp_word_ff.wait_seconds <= '0;
         rsp_word_ff.total_wait   <= wait_sum_ff;
         rsp_word_ff.served_count <= job_count_ff;
      end else if (do_update) begin
         rsp_word_ff.dropped      <= 1'b0;
         rsp_word_ff.server_index <= idx_wide[6:0];
         rsp_word_ff.wait_seconds <= wait_calc;
         rsp_word_ff.total_wait   <= new_wait_sum;
         rsp_word_ff.served_count <= new_job_count;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   // a served job always goes through the scan
   a_job_scans : assert property (@(posedge clock) disable iff (reset)
      (accept && req_word.operation == edfs_pkg::OP_JOB && !late)
      |=> state_ff == edfs_pkg::ST_SCAN)
      else $error("served job did not enter scan");

   // a word that is not dropped comes only from the write-back cycle
   a_served_from_update : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_word.dropped) |-> $past(state_ff == edfs_pkg::ST_UPDATE))
      else $error("served word outside write-back");

   // the scan never reads past the last server in use
   a_scan_in_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == edfs_pkg::ST_SCAN) |-> (scan_addr_ff <= last_ff))
      else $error("scan address past last server");

   // the clearing pass ends after the last entry
   a_sweep_ends : assert property (@(posedge clock) disable iff (reset)
      (state_ff == edfs_pkg::ST_SWEEP && sweep_addr_ff == LAST_ADDR)
      |=> state_ff == edfs_pkg::ST_IDLE)
      else $error("clearing pass did not end");

endmodule

`default_nettype wire

// File: bench/tb_earliest_free_server_dispatch.sv
`default_nettype none

module tb_earliest_free_server_dispatch;
   timeunit 1ns;
   timeprecision 1ps;

   import edfs_pkg::*;

   localparam int SERVERS = MAX_SERVERS_DEFAULT;

   // directed plan: a word to send, or a register write between words
   typedef enum bit {
      STEP_WORD,
      STEP_REG
   } step_kind_type;

   typedef struct {
      step_kind_type           kind;
      req_word_type            word;
      bit                      pinned;
      rsp_word_type            want;
      csr_index_type           index;
      logic [CSR_DATA_W-1:0]   value;
   } plan_step_type;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   req_word_type            req_word;
   logic                    rsp_strobe;
   rsp_word_type            rsp_word;
   logic                    csr_write_en;
   csr_index_type           csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   // typed-in expectation travels with the word it belongs to
   logic                    pin_valid;
   rsp_word_type            pin_word;

   // shadow of the dispatcher: free-at times, totals, registers
   logic [31:0]             free_at [SERVERS];
   logic [47:0]             wait_total;
   logic [31:0]             jobs_served;
   logic [7:0]              cfg_count;
   logic [16:0]             cfg_open;
   logic [16:0]             cfg_close;
   logic [9:0]              cfg_cap;

   rsp_word_type            assignments_due [$];
   plan_step_type           plan [$];
   int                      mismatch_count = 0;
   int                      idle_pct = 6;

   earliest_free_server_dispatch dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_word     (req_word),
      .rsp_strobe   (rsp_strobe),
      .rsp_word     (rsp_word),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #30_000_000;
      $display("TB_ERROR");
      $finish;
   end

   task automatic flag_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= 40) begin
         $display("mismatch at %0t: %s", $time, msg);
      end
   endtask

   // predicted outcome of one accepted word; updates the shadow state
   function automatic rsp_word_type predict_assignment(req_word_type w);
      rsp_word_type  r;
      int unsigned   n;
      int unsigned   best;
      int unsigned   j;
      logic [9:0]    mins;
      logic [31:0]   service;
      logic [31:0]   waited;
      logic [32:0]   free_sum;
      logic [48:0]   wait_sum;
      r = '0;
      r.dropped = 1'b1;
      r.total_wait = wait_total;
      r.served_count = jobs_served;
      if (w.operation == OP_CLEAR) begin
         foreach (free_at[i]) free_at[i] = {15'd0, cfg_open};
         wait_total = '0;
         jobs_served = '0;
         r.total_wait = '0;
         r.served_count = '0;
         return r;
      end
      // late arrival leaves everything alone
      if (w.arrival_time > cfg_close) begin
         return r;
      end
      n = cfg_count;
      if (n == 0) n = 1;
      if (n > SERVERS) n = SERVERS;
      // earliest free server, lowest index on a tie
      best = 0;
      for (j = 1; j < n; j++) begin
         if (free_at[j] < free_at[best]) best = j;
      end
      mins = (w.service_minutes > cfg_cap) ? cfg_cap : w.service_minutes;
      service = mins * SECS_PER_MIN;
      waited = '0;
      if (free_at[best] > {15'd0, w.arrival_time}) begin
         waited = free_at[best] - {15'd0, w.arrival_time};
         wait_sum = {1'b0, wait_total} + {17'd0, waited};
         wait_total = wait_sum[48] ? SUM_MAX : wait_sum[47:0];
         free_sum = {1'b0, free_at[best]} + {1'b0, service};
      end else begin
         free_sum = {16'd0, w.arrival_time} + {1'b0, service};
      end
      free_at[best] = free_sum[32] ? FREE_MAX : free_sum[31:0];
      if (jobs_served != FREE_MAX) jobs_served++;
      r.dropped = 1'b0;
      r.server_index = 7'(best);
      r.wait_seconds = waited;
      r.total_wait = wait_total;
      r.served_count = jobs_served;
      return r;
   endfunction

   // responses are checked before the word taken at the same edge is predicted
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (assignments_due.size() == 0) begin
               flag_mismatch($sformatf("word %h with nothing outstanding", rsp_word));
            end else begin
               want = assignments_due.pop_front();
               if (rsp_word.dropped !== want.dropped)
                  flag_mismatch($sformatf("dropped %b, predicted %b",
                                          rsp_word.dropped, want.dropped));
               if (rsp_word.server_index !== want.server_index)
                  flag_mismatch($sformatf("server_index %0d, predicted %0d",
                                          rsp_word.server_index, want.server_index));
               if (rsp_word.wait_seconds !== want.wait_seconds)
                  flag_mismatch($sformatf("wait_seconds %0d, predicted %0d",
                                          rsp_word.wait_seconds, want.wait_seconds));
               if (rsp_word.total_wait !== want.total_wait)
                  flag_mismatch($sformatf("total_wait %0d, predicted %0d",
                                          rsp_word.total_wait, want.total_wait));
               if (rsp_word.served_count !== want.served_count)
                  flag_mismatch($sformatf("served_count %0d, predicted %0d",
                                          rsp_word.served_count, want.served_count));
            end
         end
         if (start && !busy) begin
            want = predict_assignment(req_word);
            if (pin_valid) want = pin_word;
            assignments_due.insert(assignments_due.size(), want);
         end
      end
   end

   // random idle cycles, then hold the word until the edge that takes it
   task automatic send_word(req_word_type w, logic pinned, rsp_word_type want);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_word <= w;
      pin_valid <= pinned;
      pin_word <= want;
      do @(posedge clock); while (busy);
   endtask

   // drop start, let every outstanding word come back and the block go quiet
   task automatic hold_until_idle();
      start <= 1'b0;
      @(posedge clock);
      while (assignments_due.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // one register write, then a pause with write enable low; shadow copy keeps the field bits only
   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_SERVER_COUNT: begin
            cfg_count = value[7:0];
         end
         CSR_OPEN_TIME: begin
            cfg_open = value[16:0];
         end
         CSR_CLOSE_TIME: begin
            cfg_close = value[16:0];
         end
         CSR_MAX_SERVICE: begin
            cfg_cap = value[9:0];
         end
         default: begin
         end
      endcase
      @(posedge clock);
   endtask

   function automatic void add_job(logic [16:0] arrival, logic [9:0] mins);
      plan_step_type s;
      s = '{kind: STEP_WORD, word: '0, pinned: 1'b0, want: '0,
            index: CSR_SERVER_COUNT, value: '0};
      s.word.operation = OP_JOB;
      s.word.arrival_time = arrival;
      s.word.service_minutes = mins;
      plan.insert(plan.size(), s);
   endfunction

   function automatic void add_pinned(logic op, logic [16:0] arrival, logic [9:0] mins,
                                      logic dropped, logic [6:0] index,
                                      logic [31:0] waited, logic [47:0] total,
                                      logic [31:0] served);
      plan_step_type s;
      s = '{kind: STEP_WORD, word: '0, pinned: 1'b1, want: '0,
            index: CSR_SERVER_COUNT, value: '0};
      s.word.operation = op;
      s.word.arrival_time = arrival;
      s.word.service_minutes = mins;
      s.want.dropped = dropped;
      s.want.server_index = index;
      s.want.wait_seconds = waited;
      s.want.total_wait = total;
      s.want.served_count = served;
      plan.insert(plan.size(), s);
   endfunction

   function automatic void add_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      plan_step_type s;
      s = '{kind: STEP_REG, word: '0, pinned: 1'b0, want: '0,
            index: idx, value: value};
      plan.insert(plan.size(), s);
   endfunction

   initial begin
      req_word_type  w;
      int            t;
      int            gap_max;
      int            neff;
      int            roll;
      int            guard;
      logic [7:0]    count;
      logic [16:0]   open_s;
      logic [16:0]   close_s;
      logic [9:0]    cap;

      reset <= 1'b1;
      start <= 1'b0;
      req_word <= '0;
      pin_valid <= 1'b0;
      pin_word <= '0;
      csr_write_en <= 1'b0;
      csr_index <= CSR_SERVER_COUNT;
      csr_wdata <= '0;

      // shadow state as it comes out of reset
      cfg_count = COUNT_RESET;
      cfg_open = OPEN_RESET;
      cfg_close = CLOSE_RESET;
      cfg_cap = CAP_RESET;
      foreach (free_at[i]) free_at[i] = {15'd0, OPEN_RESET};
      wait_total = '0;
      jobs_served = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // ---------------- directed plan ----------------
      // reset config: one server free at opening, closing at 61200, 60 minute cap
      // arrival before opening waits for the server; no service keeps free-at
      add_pinned(OP_JOB, 17'd0, 10'd0, 1'b0, 7'd0, 32'd28800, 48'd28800, 32'd1);
      // one second past closing and all-ones arrival are dropped, totals held
      add_pinned(OP_JOB, 17'd61201, 10'd1023, 1'b1, 7'd0, 32'd0, 48'd28800, 32'd1);
      add_pinned(OP_JOB, 17'h1FFFF, 10'd0, 1'b1, 7'd0, 32'd0, 48'd28800, 32'd1);
      // clear with junk in the unused fields
      add_pinned(OP_CLEAR, 17'h1FFFF, 10'h3FF, 1'b1, 7'd0, 32'd0, 48'd0, 32'd0);
      // arrival exactly at a free server, service capped to 60 minutes
      add_pinned(OP_JOB, 17'd28800, 10'd1023, 1'b0, 7'd0, 32'd0, 48'd0, 32'd1);
      // arrival exactly at closing still counts
      add_pinned(OP_JOB, 17'd61200, 10'd1, 1'b0, 7'd0, 32'd0, 48'd0, 32'd2);
      // out-of-order arrival is assigned by the same rule
      add_job(17'd0, 10'd5);
      // four servers: a run of ties walks up the indexes
      add_reg(CSR_SERVER_COUNT, 17'd4);
      add_pinned(OP_CLEAR, 17'd0, 10'd0, 1'b1, 7'd0, 32'd0, 48'd0, 32'd0);
      add_job(17'd30000, 10'd10);
      add_job(17'd30000, 10'd10);
      add_job(17'd30000, 10'd10);
      add_job(17'd30000, 10'd10);
      add_job(17'd30000, 10'd0);
      // zero servers behaves as one
      add_reg(CSR_SERVER_COUNT, 17'd0);
      add_job(17'd40000, 10'd2);
      // count above the array saturates; new opening waits for a clear
      add_reg(CSR_SERVER_COUNT, 17'd255);
      add_reg(CSR_OPEN_TIME, 17'd0);
      add_reg(CSR_CLOSE_TIME, 17'd86399);
      add_reg(CSR_MAX_SERVICE, 17'd1023);
      add_job(17'd40000, 10'd1023);
      add_pinned(OP_CLEAR, 17'd0, 10'd0, 1'b1, 7'd0, 32'd0, 48'd0, 32'd0);
      add_pinned(OP_JOB, 17'd0, 10'd0, 1'b0, 7'd0, 32'd0, 48'd0, 32'd1);
      add_job(17'd86399, 10'd1023);
      // extremes the other way: closing at zero, one minute cap, late opening
      add_reg(CSR_CLOSE_TIME, 17'd0);
      add_reg(CSR_MAX_SERVICE, 17'd1);
      add_reg(CSR_OPEN_TIME, 17'd86399);
      add_job(17'd0, 10'd1023);
      add_job(17'd1, 10'd3);
      add_pinned(OP_CLEAR, 17'd0, 10'd0, 1'b1, 7'd0, 32'd0, 48'd0, 32'd0);
      add_pinned(OP_JOB, 17'd0, 10'd7, 1'b0, 7'd0, 32'd86399, 48'd86399, 32'd1);

      foreach (plan[k]) begin
         if (plan[k].kind == STEP_REG) begin
            hold_until_idle();
            write_reg(plan[k].index, plan[k].value);
         end else begin
            send_word(plan[k].word, plan[k].pinned, plan[k].want);
         end
      end

      // ---------------- random phases ----------------
      // each phase: new registers, a clear, then mostly sorted arrivals
      for (int p = 0; p < 14; p++) begin
         case (p)
            0: begin
               count = 8'd1; open_s = 17'd28800; close_s = 17'd61200; cap = 10'd60;
            end
            1: begin
               count = 8'd128; open_s = 17'd0; close_s = 17'd86399; cap = 10'd1023;
            end
            2: begin
               count = 8'd0; open_s = 17'd1000; close_s = 17'd5000; cap = 10'd10;
            end
            3: begin
               count = 8'd255; open_s = 17'd86399; close_s = 17'd86399; cap = 10'd1;
            end
            4: begin
               count = 8'd2; open_s = 17'd0; close_s = 17'd0; cap = 10'd1023;
            end
            default: begin
               // mostly few servers, now and then a wide pool
               count = ($urandom_range(9) < 7) ? 8'($urandom_range(1, 8))
                                              : 8'($urandom_range(9, 128));
               open_s = 17'($urandom_range(80000));
               close_s = 17'($urandom_range(open_s, 86399));
               if ($urandom_range(9) == 0) close_s = 17'($urandom_range(86399));
               cap = ($urandom_range(3) == 0) ? 10'($urandom_range(1, 1023))
                                              : 10'($urandom_range(1, 120));
            end
         endcase
         // one long stretch with no idling at all
         idle_pct = (p == 6) ? 0 : 6;

         hold_until_idle();
         // unused upper data bits carry junk
         write_reg(CSR_SERVER_COUNT, {9'($urandom), count});
         write_reg(CSR_OPEN_TIME, open_s);
         write_reg(CSR_CLOSE_TIME, close_s);
         write_reg(CSR_MAX_SERVICE, {7'($urandom), cap});
         w.operation = OP_CLEAR;
         w.arrival_time = 17'($urandom);
         w.service_minutes = 10'($urandom);
         send_word(w, 1'b0, '0);

         // mean gap near service over servers, so queues build up
         neff = (count == 0) ? 1 : (count > SERVERS) ? SERVERS : count;
         gap_max = cap * 60 / neff + 1;
         t = open_s;
         repeat (135) begin
            roll = $urandom_range(99);
            // now and then wait for every result before going on
            if (roll == 0) hold_until_idle();
            w.operation = OP_JOB;
            w.service_minutes = ($urandom_range(9) < 6) ? 10'($urandom_range(cap))
                                                        : 10'($urandom);
            if (roll < 3) begin
               w.operation = OP_CLEAR;
               w.arrival_time = 17'($urandom);
               t = open_s;
            end else if (roll < 9) begin
               // noise: any arrival, out of order
               w.arrival_time = 17'($urandom);
            end else begin
               w.arrival_time = 17'(t);
            end
            send_word(w, 1'b0, '0);
            if (roll >= 9) begin
               if (t > close_s) begin
                  // past closing: start a new day
                  w.operation = OP_CLEAR;
                  send_word(w, 1'b0, '0);
                  t = open_s;
               end else begin
                  t = t + $urandom_range(gap_max);
                  if (t > 86399) t = 86399;
               end
            end
         end
      end

      // ---------------- piled-up queue ----------------
      // one server, full service, everyone at midnight: waits grow with every job
      idle_pct = 6;
      hold_until_idle();
      write_reg(CSR_SERVER_COUNT, 17'd1);
      write_reg(CSR_OPEN_TIME, 17'd0);
      write_reg(CSR_CLOSE_TIME, 17'd86399);
      write_reg(CSR_MAX_SERVICE, 17'd1023);
      w.operation = OP_CLEAR;
      w.arrival_time = '0;
      w.service_minutes = '0;
      send_word(w, 1'b0, '0);
      w.operation = OP_JOB;
      w.service_minutes = 10'd1023;
      repeat (40) send_word(w, 1'b0, '0);
      w.arrival_time = 17'd86399;
      repeat (3) send_word(w, 1'b0, '0);

      // ---------------- wind down ----------------
      start <= 1'b0;
      @(posedge clock);
      guard = 0;
      while (assignments_due.size() != 0 && guard < 2000) begin
         @(posedge clock);
         guard++;
      end
      repeat (8) @(posedge clock);
      if (assignments_due.size() != 0) begin
         flag_mismatch($sformatf("%0d words never came back", assignments_due.size()));
      end
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: files.f
rtl/edfs_pkg.sv
rtl/edfs_free_mem.sv
rtl/edfs_min_scan.sv
rtl/earliest_free_server_dispatch.sv
bench/tb_earliest_free_server_dispatch.sv
